// File: hw/rtl/swmo_pkg.sv
package swmo_pkg;

   localparam int MAX_WINDOW = 64;

   localparam int SAMPLE_W   = 16;
   localparam int CFG_W      = 7;
   localparam int CFG_IDX_W  = 2;
   localparam int LEVEL_W    = 7;
   localparam int RSP_DATA_W = 24;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

   localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd64;
   localparam logic [CFG_W-1:0] MIN_FILL_RESET   = 7'd1;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_WINDOW_LEN = 2'd0,
      REG_MIN_FILL   = 2'd1
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_PROC,
      ST_TAIL,
      ST_MED,
      ST_FIN
   } state_type;

endpackage

// File: hw/rtl/sliding_window_median_offset.sv
// Items are taken only in the idle state: a new item waits until the last one has left the
// merge pass and its result is loaded. The pass walks the sorted buffer, one entry read per cycle
// while no insert holds the current entry, through its single read port, with compare logic
// checking each entry against the new and the evicted sample.
// Reset (synchronous, active high): window empty, correction 0, not locked,
// window_len 64, min_fill 1. No clearing pass; stored samples are never used unwritten.
module sliding_window_median_offset #(
   parameter int MaxWindow = swmo_pkg::MAX_WINDOW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [swmo_pkg::SAMPLE_W-1:0]       req_tdata,   // [15:0] drift_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [swmo_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [15:0] correction,
                                                            // [16] ready_res,
                                                            // [23:17] fill_level
   input  logic                                csr_we,
   input  logic [swmo_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [swmo_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
   localparam int CntW = $clog2(MaxWindow + 1);

   swmo_pkg::state_type state_ff, state_in;

   // sample window (circular) and double-buffered sorted copy
   logic signed [swmo_pkg::SAMPLE_W-1:0] wst_mem  [0:MaxWindow-1];
   logic signed [swmo_pkg::SAMPLE_W-1:0] sort_mem [0:1][0:MaxWindow-1];

   logic signed [swmo_pkg::SAMPLE_W-1:0] wst_rd_ff;
   logic signed [swmo_pkg::SAMPLE_W-1:0] sort_rd_ff;
   logic signed [swmo_pkg::SAMPLE_W-1:0] x_ff;

   logic [swmo_pkg::CFG_W-1:0] len_ff, len_in;
   logic [swmo_pkg::CFG_W-1:0] minf_ff, minf_in;
   logic [CntW-1:0]            fill_ff, fill_in;
   logic [IdxW-1:0]            slot_ff, slot_in;
   logic [CntW-1:0]            m_ff, m_in;
   logic [CntW-1:0]            k_ff, k_in;
   logic [CntW-1:0]            w_ff, w_in;
   logic                       evict_ff, evict_in;
   logic                       del_ff, del_in;
   logic                       ins_ff, ins_in;
   logic                       bank_ff, bank_in;
   logic signed [swmo_pkg::SAMPLE_W-1:0] held_ff, held_in;
   logic                       locked_ff, locked_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [swmo_pkg::SAMPLE_W-1:0] rsp_corr_ff;
   logic                       rsp_lock_ff;
   logic [swmo_pkg::LEVEL_W-1:0] rsp_fill_ff;

   logic [CntW-1:0] eff_len;
   logic [CntW-1:0] k_next;
   logic [CntW-1:0] slot_next;
   logic            req_accept;
   logic            evict_now;
   logic            x_lt_s;
   logic            s_eq_e;
   logic            ins_now;
   logic            del_now;
   logic            out_free;
   logic            rsp_load;
   logic            sort_re;
   logic            sort_rd_bank;
   logic [IdxW-1:0] sort_rd_idx;
   logic            sort_we;
   logic signed [swmo_pkg::SAMPLE_W-1:0] sort_wr_val;
   logic signed [swmo_pkg::SAMPLE_W-1:0] med_neg;

   assign req_tready = (state_ff == swmo_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_fill_ff, rsp_lock_ff, rsp_corr_ff};

   always_comb begin
      if (len_ff == '0) begin
         eff_len = CntW'(1);
      end else if (int'(len_ff) > MaxWindow) begin
         eff_len = CntW'(MaxWindow);
      end else begin
         eff_len = CntW'(len_ff);
      end
   end

   assign evict_now = (fill_ff >= eff_len);
   assign k_next    = k_ff + CntW'(1);
   assign slot_next = CntW'(slot_ff) + CntW'(1);

   // compare logic: new sample against entry, entry against evicted sample
   assign x_lt_s  = (x_ff < sort_rd_ff);
   assign s_eq_e  = (sort_rd_ff == wst_rd_ff);
   assign ins_now = ~ins_ff & x_lt_s;
   assign del_now = ~ins_now & del_ff & s_eq_e;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign med_neg  = (sort_rd_ff == swmo_pkg::SAMPLE_MIN) ? swmo_pkg::SAMPLE_MAX : -sort_rd_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swmo_pkg::ST_IDLE: begin
            if (req_accept) state_in = swmo_pkg::ST_START;
         end
         swmo_pkg::ST_START: begin
            state_in = (m_ff == '0) ? swmo_pkg::ST_TAIL : swmo_pkg::ST_PROC;
         end
         swmo_pkg::ST_PROC: begin
            if (!ins_now && (k_next >= m_ff)) state_in = swmo_pkg::ST_TAIL;
         end
         swmo_pkg::ST_TAIL: state_in = swmo_pkg::ST_MED;
         swmo_pkg::ST_MED:  state_in = swmo_pkg::ST_FIN;
         swmo_pkg::ST_FIN: begin
            if (out_free) state_in = swmo_pkg::ST_IDLE;
         end
         default: state_in = swmo_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      sort_re      = 1'b0;
      sort_rd_bank = bank_ff;
      sort_rd_idx  = k_ff[IdxW-1:0];
      sort_we      = 1'b0;
      sort_wr_val  = sort_rd_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      ins_in       = ins_ff;
      del_in       = del_ff;
      bank_in      = bank_ff;
      held_in      = held_ff;
      locked_in    = locked_ff;
      rsp_load     = 1'b0;
      unique case (state_ff)
         swmo_pkg::ST_IDLE: begin
            k_in   = '0;
            w_in   = '0;
            ins_in = 1'b0;
            del_in = evict_now;
         end
         swmo_pkg::ST_START: begin
            if (m_ff != '0) begin
               sort_re     = 1'b1;
               sort_rd_idx = '0;
            end
         end
         swmo_pkg::ST_PROC: begin
            if (ins_now) begin
               // new sample goes ahead of the held entry; entry stays for next cycle
               sort_we     = 1'b1;
               sort_wr_val = x_ff;
               w_in        = w_ff + CntW'(1);
               ins_in      = 1'b1;
            end else begin
               if (del_now) begin
                  del_in = 1'b0;
               end else begin
                  sort_we = 1'b1;
                  w_in    = w_ff + CntW'(1);
               end
               k_in = k_next;
               if (k_next < m_ff) begin
                  sort_re     = 1'b1;
                  sort_rd_idx = k_next[IdxW-1:0];
               end
            end
         end
         swmo_pkg::ST_TAIL: begin
            if (!ins_ff) begin
               sort_we     = 1'b1;
               sort_wr_val = x_ff;
               w_in        = w_ff + CntW'(1);
               ins_in      = 1'b1;
            end
         end
         swmo_pkg::ST_MED: begin
            sort_re      = 1'b1;
            sort_rd_bank = ~bank_ff;
            sort_rd_idx  = IdxW'(fill_ff >> 1);
            bank_in      = ~bank_ff;
         end
         swmo_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (int'(fill_ff) >= int'(minf_ff)) begin
                  held_in   = med_neg;
                  locked_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // config, fill count and write slot
   always_comb begin
      len_in   = len_ff;
      minf_in  = minf_ff;
      fill_in  = fill_ff;
      slot_in  = slot_ff;
      m_in     = m_ff;
      evict_in = evict_ff;
      if (req_accept) begin
         m_in     = fill_ff;
         evict_in = evict_now;
         fill_in  = evict_now ? fill_ff : fill_ff + CntW'(1);
         slot_in  = (slot_next >= eff_len) ? '0 : slot_ff + IdxW'(1);
      end
      if (csr_we) begin
         unique case (csr_index)
            swmo_pkg::REG_WINDOW_LEN: begin
               len_in  = csr_wdata;
               fill_in = '0;
               slot_in = '0;
            end
            swmo_pkg::REG_MIN_FILL: minf_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmo_pkg::ST_IDLE;
         len_ff       <= swmo_pkg::WINDOW_LEN_RESET;
         minf_ff      <= swmo_pkg::MIN_FILL_RESET;
         fill_ff      <= '0;
         slot_ff      <= '0;
         m_ff         <= '0;
         k_ff         <= '0;
         w_ff         <= '0;
         evict_ff     <= 1'b0;
         del_ff       <= 1'b0;
         ins_ff       <= 1'b0;
         bank_ff      <= 1'b0;
         held_ff      <= '0;
         locked_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         minf_ff      <= minf_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         m_ff         <= m_in;
         k_ff         <= k_in;
         w_ff         <= w_in;
         evict_ff     <= evict_in;
         del_ff       <= del_in;
         ins_ff       <= ins_in;
         bank_ff      <= bank_in;
         held_ff      <= held_in;
         locked_ff    <= locked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sample window: old entry read out as the evicted sample, new one written
   always_ff @(posedge clock) begin
      if (req_accept) begin
         wst_rd_ff        <= wst_mem[slot_ff];
         wst_mem[slot_ff] <= req_tdata;
         x_ff             <= req_tdata;
      end
   end

   // sorted buffer: read the current bank (the merged bank for the median), write the merged list into the other
   always_ff @(posedge clock) begin
      if (sort_we) begin
         sort_mem[~bank_ff][w_ff[IdxW-1:0]] <= sort_wr_val;
      end
      if (sort_re) begin
         sort_rd_ff <= sort_mem[sort_rd_bank][sort_rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_corr_ff <= held_in;
         rsp_lock_ff <= locked_in;
         rsp_fill_ff <= swmo_pkg::LEVEL_W'(fill_ff);
      end
   end

`ifndef ASSERT_OFF
   // merged list has exactly the new fill count: one in, one out when evicting
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == swmo_pkg::ST_MED) |->
         (({1'b0, w_ff} + {{CntW{1'b0}}, evict_ff}) == ({1'b0, m_ff} + {{CntW{1'b0}}, 1'b1})))
      else $error("merge wrote wrong entry count");

   // evicted sample must have been found in the sorted buffer and the new sample merged
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == swmo_pkg::ST_MED) |-> !del_ff && ins_ff)
      else $error("evicted sample or new sample not merged");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_len)
      else $error("fill count above window length");

   // a waiting item is never overwritten by the next one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_tdata))
      else $error("pending item lost");
`endif

endmodule
